// ----- src/mwpo_pkg.sv -----
package mwpo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;

    // Width of the external phase increment and offset fields.
    localparam int STEP_W  = 32;
    localparam int SUM_W   = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
    // The back end only ever looks at the top sixteen phase bits.
    localparam int TOP_W   = 16;
    localparam int TBL_N   = 2 ** SINE_TABLE_BITS;
    localparam int ADDR_W  = SINE_TABLE_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] PHASE_INC_RESET = 32'd39370534;
    localparam logic [15:0] VOLUME_RESET    = 16'd32768;

    // Full scale and its negative in the 17-bit wave domain.
    localparam logic signed [16:0] WAVE_POS_ONE = 17'sd32768;
    localparam logic signed [16:0] WAVE_NEG_ONE = -17'sd32768;
    localparam logic signed [16:0] WAVE_ZERO    = 17'sd0;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_OFFSET = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_PHASE_INC = 2'd0,
        REG_WAVE_SEL  = 2'd1,
        REG_VOLUME    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_wave       wave;
        logic [15:0] volume;
    } t_wave_cfg;

    typedef logic [15:0] t_rom [0:TBL_N];

    // Denominators (2k)(2k+1) of the sine series, for k from 1 to 6.
    localparam int SERIES_DIV [1:6] = '{6, 20, 42, 72, 110, 156};

    // Quarter-wave sine, Q15, from a truncated Taylor series on a Q30 angle.
    function automatic t_rom build_rom();
        t_rom                rom;
        logic [63:0]         x;
        logic [63:0]         t;
        logic signed [63:0]  sum;
        logic [63:0]         v;
        for (int i = 0; i <= TBL_N; i++) begin
            x   = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            t   = x;
            sum = $signed(x);
            for (int k = 1; k <= 6; k++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / 64'(SERIES_DIV[k]);
                if (k % 2 == 1) begin
                    sum = sum - $signed(t);
                end else begin
                    sum = sum + $signed(t);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            v = (64'(sum) * 64'd32768 + 64'd536870912) >> 30;
            if (v > 64'd32768) begin
                v = 64'd32768;
            end
            rom[i] = v[15:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

endpackage

// ----- src/mwpo_front.sv -----
module mwpo_front
    import mwpo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    input  logic [STEP_W-1:0] i_phase_offset,
    input  logic [STEP_W-1:0] i_phase_inc,
    input  logic              i_queue_full,
    output logic              o_stall,
    output logic              o_push,
    output logic [TOP_W-1:0]  o_push_phase
);

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [SUM_W-1:0]      phase_sum;
    logic [STEP_W-1:0]     step;
    logic                  accept;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    // A tick samples the phase before it advances; an offset only moves it.
    assign step      = (t_cmd'(i_command) == CMD_OFFSET) ? i_phase_offset : i_phase_inc;
    assign phase_sum = SUM_W'(r_phase) + SUM_W'(step);
    assign n_phase   = phase_sum[PHASE_BITS-1:0];

    assign o_push       = accept && (t_cmd'(i_command) == CMD_TICK);
    assign o_push_phase = r_phase[PHASE_BITS-1 -: TOP_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

endmodule

// ----- src/mwpo_queue.sv -----
module mwpo_queue
    import mwpo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [TOP_W-1:0] i_data,
    input  logic             i_pop,
    output logic [TOP_W-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [TOP_W-1:0]  r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- src/mwpo_back.sv -----
module mwpo_back
    import mwpo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_wave_cfg          i_cfg,
    input  logic               i_empty,
    input  logic [TOP_W-1:0]   i_phase,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample
);

    logic                     en;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ADDR_W-1:0]        addr;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic                     r_out_valid;
    logic [TOP_W-1:0]         r_p1;
    logic [15:0]              r_rom;
    logic signed [16:0]       r_val;
    logic signed [16:0]       n_val;
    logic signed [33:0]       r_prod;
    logic signed [33:0]       rounded;
    logic signed [18:0]       scaled;
    logic signed [15:0]       n_sample;

    logic signed [16:0]       saw;
    logic signed [16:0]       mag;
    logic signed [17:0]       tri_wide;
    logic signed [16:0]       sine;

    // The whole pipe moves together unless a finished beat is held.
    assign en    = !(r_out_valid && i_stall);
    assign o_pop = en && !i_empty;

    // Odd quadrants read the quarter table backwards.
    assign idx  = i_phase[TOP_W-3 -: SINE_TABLE_BITS];
    assign addr = i_phase[TOP_W-2] ? (ADDR_W'(TBL_N) - {1'b0, idx}) : {1'b0, idx};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1  <= i_phase;
            r_rom <= SINE_ROM[addr];
        end
    end

    assign saw      = $signed({~r_p1[TOP_W-1], ~r_p1[TOP_W-1], r_p1[TOP_W-2:0]});
    assign mag      = saw[16] ? -saw : saw;
    assign tri_wide = $signed({mag, 1'b0}) - 18'sd32768;
    assign sine     = r_p1[TOP_W-1] ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});

    always_comb begin
        case (i_cfg.wave)
            WAVE_SINE:     n_val = sine;
            WAVE_SQUARE:   n_val = r_p1[TOP_W-1] ? WAVE_NEG_ONE : WAVE_POS_ONE;
            WAVE_SAW:      n_val = saw;
            WAVE_TRIANGLE: n_val = tri_wide[16:0];
            default:       n_val = WAVE_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_val  <= n_val;
            r_prod <= r_val * $signed({1'b0, i_cfg.volume});
        end
    end

    // Round half up, then clip to the Q1.15 range.
    assign rounded = r_prod + 34'sd16384;
    assign scaled  = 19'(rounded >>> 15);

    always_comb begin
        if (scaled > 19'sd32767) begin
            n_sample = 16'sh7fff;
        end else if (scaled < -19'sd32768) begin
            n_sample = 16'sh8000;
        end else begin
            n_sample = scaled[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_sample <= n_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- src/multi_waveform_phase_oscillator.sv -----
// Phase-accumulator oscillator giving sine, square, saw and triangle samples.
// Input channel: i_valid, o_stall, i_command, i_phase_offset. A tick beat
// (command 0) yields one sample at the current phase and then advances the
// phase by phase_increment; an offset beat (command 1) adds i_phase_offset to
// the phase and yields nothing.
// Output channel: o_valid, i_stall, o_sample (signed Q1.15, volume applied,
// rounded and saturated).
// Registers on the APB port: 0x0 phase_increment, 0x4 wave_select,
// 0x8 volume. Change them only while the block is idle.
// Throughput is one beat per clock while o_stall is low. A taken tick beat
// writes its phase into the queue; registers then hold the sine table read
// as the phase leaves the queue, the formed waveform, the volume multiply
// and the rounded, clipped sample in the output register.
// A four-entry queue parts the phase accumulator from the sample pipeline.
// When the receiver stalls, the pipeline holds and the queue fills; o_stall
// rises only once it is full. Reset clears the phase, empties the queue and
// the pipeline, and restores the register defaults.
module multi_waveform_phase_oscillator
    import mwpo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [31:0]        i_phase_offset,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0]      r_phase_inc;
    t_wave            r_wave;
    logic [15:0]      r_volume;
    t_reg_idx         reg_idx;
    logic             cfg_write;
    t_wave_cfg        wave_cfg;

    logic             q_push;
    logic [TOP_W-1:0] q_push_data;
    logic             q_pop;
    logic [TOP_W-1:0] q_data;
    logic             q_full;
    logic             q_empty;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= PHASE_INC_RESET;
            r_wave      <= WAVE_SINE;
            r_volume    <= VOLUME_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PHASE_INC: r_phase_inc <= pwdata;
                REG_WAVE_SEL:  r_wave      <= t_wave'(pwdata[1:0]);
                REG_VOLUME:    r_volume    <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PHASE_INC: prdata = r_phase_inc;
            REG_WAVE_SEL:  prdata = {30'd0, r_wave};
            REG_VOLUME:    prdata = {16'd0, r_volume};
            default:       prdata = 32'd0;
        endcase
    end

    assign wave_cfg.wave   = r_wave;
    assign wave_cfg.volume = r_volume;

    mwpo_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_command      (i_command),
        .i_phase_offset (i_phase_offset),
        .i_phase_inc    (r_phase_inc),
        .i_queue_full   (q_full),
        .o_stall        (o_stall),
        .o_push         (q_push),
        .o_push_phase   (q_push_data)
    );

    mwpo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_data),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mwpo_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (wave_cfg),
        .i_empty  (q_empty),
        .i_phase  (q_data),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_sample (o_sample)
    );

endmodule

// ----- src/mwpo_checker.sv -----
module mwpo_sva (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_sample,
    input logic               o_stall,
    input logic               pready
);

    // A held sample stays put until the receiver takes it.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample))
        else $error("held output beat changed");

    // Reset empties the sample pipeline.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Reset empties the queue, so the input is open straight away.
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    a_pready: assert property (@(posedge i_clk)
        pready)
        else $error("register port not ready");

endmodule

bind multi_waveform_phase_oscillator mwpo_sva u_checker (.*);
